>>> hw/rtl/pba_pkg.sv
package pba_pkg;

   // Serial multiplier operand and product widths.
   localparam int MA_W = 42;
   localparam int MB_W = 25;
   localparam int MP_W = MA_W + MB_W;

   // Width of the internal sums before they are saturated back to 40 bits.
   localparam int WD_W = 46;

   typedef logic signed [39:0]     term_type;
   typedef logic signed [WD_W-1:0] wide_type;

   // Configuration register indexes.
   typedef logic [3:0] csr_index_type;
   localparam csr_index_type CSR_GAIN_K    = 4'd0;
   localparam csr_index_type CSR_WEIGHT_B  = 4'd1;
   localparam csr_index_type CSR_INT_COEF  = 4'd2;
   localparam csr_index_type CSR_WINDUP    = 4'd3;
   localparam csr_index_type CSR_DPOLE     = 4'd4;
   localparam csr_index_type CSR_DGAIN     = 4'd5;
   localparam csr_index_type CSR_AW_ON     = 4'd6;
   localparam csr_index_type CSR_FB_ON     = 4'd7;

   // Input kinds.
   localparam logic KIND_CONTROL = 1'b0;
   localparam logic KIND_FFWD    = 1'b1;

   // Sequencer states, one per product plus idle and output.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KBP,
      ST_FFP,
      ST_KYP,
      ST_KB,
      ST_FF,
      ST_KY,
      ST_DP,
      ST_DG,
      ST_IC,
      ST_WU,
      ST_DONE
   } seq_state_type;

   // Sign extend a 40-bit term to the wide sum width.
   function automatic wide_type widen(input term_type x);
      return {{(WD_W-40){x[39]}}, x};
   endfunction

   // True when a wide value lies outside the signed 40-bit range.
   function automatic logic sat_hit(input wide_type x);
      return !((x[WD_W-1:39] == '0) || (x[WD_W-1:39] == '1));
   endfunction

   // Saturate a wide value to the signed 40-bit range.
   function automatic term_type sat40(input wide_type x);
      term_type r;
      if (!sat_hit(x)) begin
         r = x[39:0];
      end else if (x[WD_W-1]) begin
         r = {1'b1, 39'd0};
      end else begin
         r = {1'b0, {39{1'b1}}};
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/pid_bumpless_antiwindup_top.sv
// Each input transaction runs its products on one serial multiplier: with feedback and
// anti-windup on, ten products, each a start, 25 multiplier bits and done; then a load.
// Anti-windup off leaves nine products, a feedforward update two, and feedback off none.
// One item at a time; the next is accepted in the cycle after the result is registered, and
// the result is registered only once the previous result has been taken.
// Synchronous active-high reset restores control, configuration and controller state only.
module pid_bumpless_antiwindup_top
   import pba_pkg::*;
#(
   parameter int unsigned OUT_MAX = 4095
)
(
   input  logic          clock,
   input  logic          reset,
   // Input samples.
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [31:0]   req_tdata,   // reference [15:0], measured [31:16]
   input  logic          req_tuser,   // kind
   // Results.
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [23:0]   rsp_tdata,   // control [23:0]
   output logic          rsp_tuser,   // clamped
   // Register writes.
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [23:0]   csr_data
);

   localparam term_type LIM_TOP = term_type'(OUT_MAX) <<< 16;

   seq_state_type state_ff, state_in;
   logic started_ff, started_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic signed [23:0] gain_k_ff, gain_k_in;
   logic signed [23:0] weight_b_ff, weight_b_in;
   logic signed [23:0] icoef_ff, icoef_in;
   logic [16:0]        windup_ff, windup_in;
   logic [16:0]        pole_ff, pole_in;
   logic signed [23:0] dgain_ff, dgain_in;
   logic               aw_on_ff, aw_on_in;
   logic               fb_on_ff, fb_on_in;

   term_type           integ_ff, integ_in;
   term_type           dacc_ff, dacc_in;
   logic [15:0]        mprev_ff, mprev_in;
   logic signed [23:0] gprev_ff, gprev_in;
   logic signed [23:0] wprev_ff, wprev_in;
   term_type           ffterm_ff, ffterm_in;

   logic               kind_ff, kind_in;
   logic [15:0]        r_ff, r_in;
   logic [15:0]        y_ff, y_in;
   logic signed [MA_W-1:0] t_ff, t_in;
   wide_type           bump_ff, bump_in;
   wide_type           ky_ff, ky_in;
   term_type           u_ff, u_in;
   term_type           v_ff, v_in;
   logic               hit_ff, hit_in;
   logic [23:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_user_ff, rsp_user_in;

   logic                   mul_start;
   logic                   mul_done;
   logic signed [MA_W-1:0] mul_a;
   logic signed [MB_W-1:0] mul_b;
   logic signed [MP_W-1:0] mul_p;
   wide_type               p8;
   wide_type               p16;

   logic signed [16:0] dy;
   logic signed [16:0] ry;
   logic signed [40:0] uv;
   logic signed [40:0] u_neg;
   logic signed [40:0] q_mag;
   logic signed [40:0] q_int;
   logic [15:0]        req_r;
   logic [15:0]        req_y;

   // Limit to 0..OUT_MAX when anti-windup is on; returns {hit, value}.
   function automatic logic [40:0] limit_fn(input term_type v, input logic on);
      logic [40:0] r;
      if (on && (v > LIM_TOP)) begin
         r = {1'b1, LIM_TOP};
      end else if (on && v[39]) begin
         r = {1'b1, 40'd0};
      end else begin
         r = {1'b0, v};
      end
      return r;
   endfunction

   pba_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_p)
   );

   assign p8  = mul_p[8 +: WD_W];
   assign p16 = mul_p[16 +: WD_W];

   assign req_r = req_tdata[15:0];
   assign req_y = req_tdata[31:16];
   assign dy    = $signed({1'b0, y_ff}) - $signed({1'b0, mprev_ff});
   assign ry    = $signed({1'b0, r_ff}) - $signed({1'b0, y_ff});
   assign uv    = $signed({u_ff[39], u_ff}) - $signed({v_ff[39], v_ff});

   // Truncate the limited value toward zero to an integer.
   assign u_neg = -$signed({u_ff[39], u_ff});
   assign q_mag = u_neg >>> 16;
   assign q_int = u_ff[39] ? -q_mag : $signed({u_ff[39], u_ff}) >>> 16;

   // Multiplier operands for each product.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_KBP: begin
            mul_a = {{(MA_W-24){gprev_ff[23]}}, gprev_ff};
            mul_b = {{(MB_W-24){wprev_ff[23]}}, wprev_ff};
         end
         ST_FFP, ST_FF: begin
            mul_a = t_ff;
            mul_b = {{(MB_W-16){1'b0}}, r_ff};
         end
         ST_KYP: begin
            mul_a = {{(MA_W-24){gprev_ff[23]}}, gprev_ff};
            mul_b = {{(MB_W-16){1'b0}}, y_ff};
         end
         ST_KB: begin
            mul_a = {{(MA_W-24){gain_k_ff[23]}}, gain_k_ff};
            mul_b = {{(MB_W-24){weight_b_ff[23]}}, weight_b_ff};
         end
         ST_KY: begin
            mul_a = {{(MA_W-24){gain_k_ff[23]}}, gain_k_ff};
            mul_b = {{(MB_W-16){1'b0}}, y_ff};
         end
         ST_DP: begin
            mul_a = {{(MA_W-40){dacc_ff[39]}}, dacc_ff};
            mul_b = {{(MB_W-17){1'b0}}, pole_ff};
         end
         ST_DG: begin
            mul_a = {{(MA_W-24){dgain_ff[23]}}, dgain_ff};
            mul_b = {{(MB_W-17){dy[16]}}, dy};
         end
         ST_IC: begin
            mul_a = {{(MA_W-24){icoef_ff[23]}}, icoef_ff};
            mul_b = {{(MB_W-17){ry[16]}}, ry};
         end
         ST_WU: begin
            mul_a = {{(MA_W-41){uv[40]}}, uv};
            mul_b = {{(MB_W-17){1'b0}}, windup_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Sequencer: next state, register writes and the step arithmetic.
   always_comb begin
      logic [40:0] lim;
      term_type    dsat;
      term_type    fb;
      wide_type    sum;
      wide_type    vsum;

      state_in     = state_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff;
      gain_k_in    = gain_k_ff;
      weight_b_in  = weight_b_ff;
      icoef_in     = icoef_ff;
      windup_in    = windup_ff;
      pole_in      = pole_ff;
      dgain_in     = dgain_ff;
      aw_on_in     = aw_on_ff;
      fb_on_in     = fb_on_ff;
      integ_in     = integ_ff;
      dacc_in      = dacc_ff;
      mprev_in     = mprev_ff;
      gprev_in     = gprev_ff;
      wprev_in     = wprev_ff;
      ffterm_in    = ffterm_ff;
      kind_in      = kind_ff;
      r_in         = r_ff;
      y_in         = y_ff;
      t_in         = t_ff;
      bump_in      = bump_ff;
      ky_in        = ky_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      hit_in       = hit_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      mul_start    = 1'b0;
      lim          = '0;
      dsat         = '0;
      fb           = '0;
      sum          = '0;
      vsum         = '0;

      // Register writes; turning feedback off clears the integral.
      if (csr_valid) begin
         case (csr_index)
            CSR_GAIN_K:   gain_k_in   = csr_data;
            CSR_WEIGHT_B: weight_b_in = csr_data;
            CSR_INT_COEF: icoef_in    = csr_data;
            CSR_WINDUP:   windup_in   = csr_data[16:0];
            CSR_DPOLE:    pole_in     = csr_data[16:0];
            CSR_DGAIN:    dgain_in    = csr_data;
            CSR_AW_ON:    aw_on_in    = csr_data[0];
            CSR_FB_ON: begin
               if (fb_on_ff && !csr_data[0]) begin
                  integ_in = '0;
               end
               fb_on_in = csr_data[0];
            end
            default: begin
            end
         endcase
      end

      // The result register empties when its transaction completes.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // Each product state starts the multiplier once and waits for it.
      if ((state_ff != ST_IDLE) && (state_ff != ST_DONE)) begin
         if (!started_ff) begin
            mul_start  = 1'b1;
            started_in = 1'b1;
         end else if (mul_done) begin
            started_in = 1'b0;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in = req_tuser;
               r_in    = req_r;
               y_in    = req_y;
               if (req_tuser == KIND_FFWD) begin
                  state_in = ST_KB;
               end else if (fb_on_ff) begin
                  state_in = ST_KBP;
               end else begin
                  // Feedback off: output the limited feedforward term.
                  gprev_in = gain_k_ff;
                  wprev_in = weight_b_ff;
                  mprev_in = req_y;
                  lim      = limit_fn(ffterm_ff, aw_on_ff);
                  v_in     = ffterm_ff;
                  u_in     = lim[39:0];
                  hit_in   = lim[40];
                  state_in = ST_DONE;
               end
            end
         end
         ST_KBP: begin
            if (mul_done) begin
               t_in     = p16[MA_W-1:0];
               state_in = ST_FFP;
            end
         end
         ST_FFP: begin
            if (mul_done) begin
               bump_in  = p8;
               state_in = ST_KYP;
            end
         end
         ST_KYP: begin
            if (mul_done) begin
               bump_in  = bump_ff - p8;
               state_in = ST_KB;
            end
         end
         ST_KB: begin
            if (mul_done) begin
               t_in     = p16[MA_W-1:0];
               state_in = ST_FF;
            end
         end
         ST_FF: begin
            if (mul_done) begin
               if (kind_ff == KIND_FFWD) begin
                  ffterm_in = sat40(p8);
                  lim       = limit_fn(sat40(p8), aw_on_ff);
                  v_in      = sat40(p8);
                  u_in      = lim[39:0];
                  hit_in    = lim[40];
                  state_in  = ST_DONE;
               end else begin
                  bump_in  = bump_ff - p8;
                  state_in = ST_KY;
               end
            end
         end
         ST_KY: begin
            if (mul_done) begin
               // Bumpless correction for the change of gain and weight.
               ky_in    = p8;
               sum      = widen(integ_ff) + bump_ff + p8;
               integ_in = sat40(sum);
               gprev_in = gain_k_ff;
               wprev_in = weight_b_ff;
               state_in = ST_DP;
            end
         end
         ST_DP: begin
            if (mul_done) begin
               t_in     = p16[MA_W-1:0];
               state_in = ST_DG;
            end
         end
         ST_DG: begin
            if (mul_done) begin
               // Filtered derivative, feedback sum and output limit.
               sum      = {{(WD_W-MA_W){t_ff[MA_W-1]}}, t_ff} - p8;
               dsat     = sat40(sum);
               dacc_in  = dsat;
               fb       = sat40(widen(integ_ff) + widen(dsat) - ky_ff);
               vsum     = widen(ffterm_ff) + widen(fb);
               lim      = limit_fn(sat40(vsum), aw_on_ff);
               v_in     = sat40(vsum);
               u_in     = lim[39:0];
               hit_in   = lim[40] | sat_hit(vsum);
               mprev_in = y_ff;
               state_in = ST_IC;
            end
         end
         ST_IC: begin
            if (mul_done) begin
               integ_in = sat40(widen(integ_ff) + p8);
               state_in = aw_on_ff ? ST_WU : ST_DONE;
            end
         end
         ST_WU: begin
            if (mul_done) begin
               // Back-calculation from the limited output.
               integ_in = sat40(widen(integ_ff) + p16);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = q_int[23:0];
               rsp_user_in  = hit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control, configuration and controller state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gain_k_ff    <= '0;
         weight_b_ff  <= 24'sd65536;
         icoef_ff     <= '0;
         windup_ff    <= '0;
         pole_ff      <= '0;
         dgain_ff     <= '0;
         aw_on_ff     <= 1'b1;
         fb_on_ff     <= 1'b1;
         integ_ff     <= '0;
         dacc_ff      <= '0;
         mprev_ff     <= '0;
         gprev_ff     <= '0;
         wprev_ff     <= 24'sd65536;
         ffterm_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
         gain_k_ff    <= gain_k_in;
         weight_b_ff  <= weight_b_in;
         icoef_ff     <= icoef_in;
         windup_ff    <= windup_in;
         pole_ff      <= pole_in;
         dgain_ff     <= dgain_in;
         aw_on_ff     <= aw_on_in;
         fb_on_ff     <= fb_on_in;
         integ_ff     <= integ_in;
         dacc_ff      <= dacc_in;
         mprev_ff     <= mprev_in;
         gprev_ff     <= gprev_in;
         wprev_ff     <= wprev_in;
         ffterm_ff    <= ffterm_in;
      end
   end

   // Working registers of the current item and the result payload.
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      r_ff        <= r_in;
      y_ff        <= y_in;
      t_ff        <= t_in;
      bump_ff     <= bump_in;
      ky_ff       <= ky_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      hit_ff      <= hit_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign csr_ready  = 1'b1;

endmodule

>>> hw/rtl/pba_mul.sv
module pba_mul
   import pba_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [MA_W-1:0]  a,
   input  logic signed [MB_W-1:0]  b,
   output logic                    done,
   output logic signed [MP_W-1:0]  prod
);

   localparam logic [4:0] LAST = 5'(MB_W - 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [4:0]             cnt_ff, cnt_in;
   logic signed [MP_W-1:0] acc_ff, acc_in;
   logic signed [MP_W-1:0] a_ff, a_in;
   logic signed [MB_W-1:0] b_ff, b_in;

   // One multiplier bit per cycle, LSB first; the sign bit carries negative weight.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         a_in    = {{(MP_W-MA_W){a[MA_W-1]}}, a};
         b_in    = b;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = (cnt_ff == LAST) ? acc_ff - a_ff : acc_ff + a_ff;
         end
         a_in   = a_ff <<< 1;
         b_in   = b_ff >>> 1;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Operand and product registers.
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

>>> tb/pba_checker.sv
module pba_checker
   import pba_pkg::*;
#(
   parameter int unsigned OUT_MAX = 4095
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tready,
   input  logic [31:0]   req_tdata,   // reference [15:0], measured [31:16]
   input  logic          req_tuser,   // kind
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic [23:0]   rsp_tdata,   // control [23:0]
   input  logic          rsp_tuser,   // clamped
   input  logic          csr_valid,
   input  logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [23:0]   csr_data,
   output int            errors,
   output int            pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint TERM_MAX = 64'sd549755813887;
   localparam longint TERM_MIN = -TERM_MAX - 1;

   typedef struct packed {
      logic [23:0] control;
      logic        clamped;
   } drive_type;

   drive_type owed_drive[$];

   // Register copy, sign extended where the register is signed.
   longint gain, weight, int_coef, wu_coef, pole, d_gain;
   bit     aw_on, fb_on;

   // Controller state.
   longint integ, deriv, y_last, gain_last, weight_last, u_ff, u_fb;

   function automatic longint clip40(input longint x);
      return (x > TERM_MAX) ? TERM_MAX : (x < TERM_MIN) ? TERM_MIN : x;
   endfunction

   function automatic longint sx24(input logic [23:0] v);
      return longint'(signed'(v));
   endfunction

   // Feedforward product K*b*r and measurement product K*y, both Q.16.
   function automatic longint kbr(input longint k, input longint w, input longint r);
      return (((k * w) >>> 16) * r) >>> 8;
   endfunction

   function automatic longint kmy(input longint k, input longint y);
      return (k * y) >>> 8;
   endfunction

   // Output limiting: clamp to 0..OUT_MAX with anti-windup, pass through otherwise.
   function automatic longint bound_u(input longint v, inout bit hit);
      longint top;
      top = longint'(OUT_MAX) * 65536;
      if (!aw_on) return v;
      if (v > top) begin
         hit = 1;
         return top;
      end
      if (v < 0) begin
         hit = 1;
         return 0;
      end
      return v;
   endfunction

   function automatic drive_type pid_step(input logic kind, input longint r, input longint y);
      bit        hit;
      longint    v, u, bump, p, d, q;
      drive_type res;
      hit = 0;
      if (kind == KIND_FFWD) begin
         u_ff = clip40(kbr(gain, weight, r));
         u_fb = 0;
         v = u_ff;
         u = bound_u(v, hit);
      end else if (fb_on) begin
         // Bumpless correction keeps u continuous across a gain or weight change.
         bump = kbr(gain_last, weight_last, r) - kmy(gain_last, y)
              - kbr(gain, weight, r) + kmy(gain, y);
         integ = clip40(integ + bump);
         gain_last = gain;
         weight_last = weight;
         p = -kmy(gain, y);
         d = ((pole * deriv) >>> 16) - ((d_gain * (y - y_last)) >>> 8);
         deriv = clip40(d);
         u_fb = clip40(p + integ + deriv);
         q = u_ff + u_fb;
         v = clip40(q);
         if (v != q) hit = 1;
         u = bound_u(v, hit);
         integ = clip40(integ + ((int_coef * (r - y)) >>> 8));
         if (aw_on) integ = clip40(integ + ((wu_coef * (u - v)) >>> 16));
         y_last = y;
      end else begin
         gain_last = gain;
         weight_last = weight;
         u_fb = 0;
         v = u_ff;
         u = bound_u(v, hit);
         y_last = y;
      end
      q = (u >= 0) ? (u >>> 16) : -((-u) >>> 16);
      res.control = q[23:0];
      res.clamped = hit;
      return res;
   endfunction

   always @(posedge clock) begin
      drive_type want;
      if (reset) begin
         gain = 0; weight = 65536; int_coef = 0; wu_coef = 0; pole = 0; d_gain = 0;
         aw_on = 1; fb_on = 1;
         integ = 0; deriv = 0; y_last = 0; gain_last = 0; weight_last = 65536;
         u_ff = 0; u_fb = 0;
         owed_drive.delete();
         errors = 0;
      end else begin
         // Register writes.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GAIN_K:   gain = sx24(csr_data);
               CSR_WEIGHT_B: weight = sx24(csr_data);
               CSR_INT_COEF: int_coef = sx24(csr_data);
               CSR_WINDUP:   wu_coef = longint'(csr_data[16:0]);
               CSR_DPOLE:    pole = longint'(csr_data[16:0]);
               CSR_DGAIN:    d_gain = sx24(csr_data);
               CSR_AW_ON:    aw_on = csr_data[0];
               CSR_FB_ON: begin
                  if (fb_on && !csr_data[0]) integ = 0;
                  fb_on = csr_data[0];
               end
               default: ;
            endcase
         end
         // Input transaction: predict its result.
         if (req_tvalid && req_tready)
            owed_drive.push_back(pid_step(req_tuser, longint'(req_tdata[15:0]),
                                          longint'(req_tdata[31:16])));
         // Result transaction: compare with the oldest prediction.
         if (rsp_tvalid && rsp_tready) begin
            if (owed_drive.size() == 0) begin
               errors++;
               $display("%0t: unexpected result control %h clamped %b", $time,
                        rsp_tdata, rsp_tuser);
            end else begin
               want = owed_drive.pop_front();
               if (want.control !== rsp_tdata || want.clamped !== rsp_tuser) begin
                  errors++;
                  $display("%0t: expected control %h clamped %b, got control %h clamped %b",
                           $time, want.control, want.clamped, rsp_tdata, rsp_tuser);
               end
            end
         end
      end
      pending = owed_drive.size();
   end

endmodule

>>> tb/tb.sv
module tb;
   import pba_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int            STALL_LIMIT = 20000;
   localparam csr_index_type CSR_SPARE   = 4'hF;

   logic          clock = 0;
   logic          reset = 1;
   logic          req_tvalid = 0;
   logic          req_tready;
   logic [31:0]   req_tdata = '0;   // reference [15:0], measured [31:16]
   logic          req_tuser = 0;    // kind
   logic          rsp_tvalid;
   logic          rsp_tready = 0;
   logic [23:0]   rsp_tdata;        // control [23:0]
   logic          rsp_tuser;        // clamped
   logic          csr_valid = 0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_GAIN_K;
   logic [23:0]   csr_data = '0;
   int            errors, pending;
   bit            hold_rsp = 0;
   bit            req_burst = 0;
   int            idle_cycles = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   pid_bumpless_antiwindup_top #(.OUT_MAX(4095)) dut (.*);

   pba_checker #(.OUT_MAX(4095)) chk (.*);

   // Receiver: random stalls, stretches without stalls, and one long hold-off.
   initial begin
      int  gap;
      bit  burst;
      burst = 0;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 15) == 0) burst = !burst;
         gap = burst ? 0 : $urandom_range(0, 15);
         if (hold_rsp) gap = 3000;
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
            hold_rsp = 0;
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send(input logic kind, input logic [15:0] r, input logic [15:0] y);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= kind;
      req_tdata  <= {y, r};
      do @(posedge clock); while (!req_tready);
   endtask

   // Wait until every result has come back.
   task automatic drain();
      req_tvalid <= 0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   task automatic set_reg(input csr_index_type idx, input logic [23:0] val);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   task automatic set_all(input logic [23:0] k, input logic [23:0] b, input logic [23:0] ic,
                          input logic [23:0] wu, input logic [23:0] dp,
                          input logic [23:0] dg, input logic aw, input logic fb);
      drain();
      set_reg(CSR_GAIN_K, k);
      set_reg(CSR_WEIGHT_B, b);
      set_reg(CSR_INT_COEF, ic);
      set_reg(CSR_WINDUP, wu);
      set_reg(CSR_DPOLE, dp);
      set_reg(CSR_DGAIN, dg);
      set_reg(CSR_AW_ON, {23'd0, aw});
      set_reg(CSR_FB_ON, {23'd0, fb});
   endtask

   function automatic logic [23:0] pick_coef(input int mode);
      case (mode)
         0: return 24'($signed($urandom_range(0, 524288)) - 262144);
         1: return 24'($urandom);
         default: begin
            case ($urandom_range(0, 2))
               0: return 24'h7FFFFF;
               1: return 24'h800000;
               default: return 24'h000000;
            endcase
         end
      endcase
   endfunction

   function automatic logic [23:0] pick_frac(input int mode);
      case (mode)
         0: return 24'($urandom_range(0, 65536));
         1: return 24'($urandom);
         default: return $urandom_range(0, 1) ? 24'd65536 : 24'h01FFFF;
      endcase
   endfunction

   initial begin
      int           mode;
      logic [15:0]  r, y;
      repeat (4) @(posedge clock);
      reset <= 0;

      // Reset settings, field extremes and both kinds.
      send(KIND_CONTROL, 16'h0000, 16'h0000);
      send(KIND_CONTROL, 16'hFFFF, 16'hFFFF);
      send(KIND_FFWD, 16'hFFFF, 16'h0000);
      send(KIND_CONTROL, 16'h0100, 16'h0080);

      // Typical gains with clamping to both ends and a derivative kick.
      set_all(24'h010000, 24'h008000, 24'h000800, 24'h004000, 24'h00C000, 24'h020000, 1, 1);
      send(KIND_FFWD, 16'h8000, 16'h0000);
      send(KIND_CONTROL, 16'h8000, 16'h0000);
      send(KIND_CONTROL, 16'h0000, 16'hFFFF);
      send(KIND_CONTROL, 16'hFFFF, 16'h0000);
      // Gain change exercises the bumpless correction.
      drain();
      set_reg(CSR_GAIN_K, 24'h030000);
      send(KIND_CONTROL, 16'h4000, 16'h2000);

      // Extreme coefficients, anti-windup off: 40-bit saturation.
      set_all(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h010000, 24'h010000, 24'h800000, 0, 1);
      send(KIND_FFWD, 16'hFFFF, 16'h0000);
      send(KIND_CONTROL, 16'hFFFF, 16'h0000);
      send(KIND_CONTROL, 16'h0000, 16'hFFFF);
      send(KIND_CONTROL, 16'hFFFF, 16'hFFFF);

      // Feedback off, written while on so the integral clears, then written again.
      drain();
      set_reg(CSR_FB_ON, 24'd0);
      send(KIND_CONTROL, 16'h1234, 16'h4321);
      drain();
      set_reg(CSR_FB_ON, 24'd0);
      set_reg(CSR_SPARE, 24'hFFFFFF);
      send(KIND_CONTROL, 16'hFFFF, 16'h0000);
      drain();
      set_reg(CSR_FB_ON, 24'hFFFFFF);
      send(KIND_CONTROL, 16'h0000, 16'h0000);

      // Random phases with random settings.
      for (int phase = 0; phase < 11; phase++) begin
         mode = $urandom_range(0, 3);
         if (mode == 3) mode = 0;
         set_all(pick_coef(mode), pick_coef(mode), pick_coef(mode), pick_frac(mode),
                 pick_frac(mode), pick_coef(mode), 1'($urandom), 1'($urandom_range(0, 3) != 0));
         req_burst = ($urandom_range(0, 3) == 0);
         if (phase == 3) begin
            req_burst = 1;
            hold_rsp = 1;
         end
         for (int n = 0; n < 50; n++) begin
            r = 16'($urandom);
            y = $urandom_range(0, 1) ? 16'($urandom) : r + 16'($urandom_range(0, 511)) - 16'd256;
            send($urandom_range(0, 7) == 0 ? KIND_FFWD : KIND_CONTROL, r, y);
         end
      end

      drain();
      repeat (300) @(posedge clock);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/pba_pkg.sv
hw/rtl/pba_mul.sv
hw/rtl/pid_bumpless_antiwindup_top.sv
tb/pba_checker.sv
tb/tb.sv
